// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros shared by the RTL. Synthesis builds see empty
// bodies.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_CLK(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");

`define ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");

`else

`define ASSERT_CLK(label, clk, rst_n, prop)

`define ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

// ===== sv/fwa_pkg.sv =====
// ----------------------------------------------------------------------------
// fwa_pkg
// Types and constants of the sliding-window frame rate averager.
// ----------------------------------------------------------------------------
package fwa_pkg;

	localparam int STAMP_W = 32;
	localparam int FPS_W = 24;
	localparam int MS_PER_SECOND = 1000;
	localparam int FRACTION_BITS = 8;
	localparam logic [FPS_W-1:0] FPS_MAX = {FPS_W{1'b1}};
	localparam int WINDOW_DEPTH_DEFAULT = 64;

	localparam logic OP_START = 1'b0;
	localparam logic OP_TICK = 1'b1;

	typedef struct packed {
		logic op;
		logic [STAMP_W-1:0] now_ms;
	} item_t;

	typedef struct packed {
		logic [FPS_W-1:0] fps_q8;
		logic saturated;
	} result_t;

endpackage

// ===== sv/frame_rate_window_average.sv =====
// Flow: a start goes from idle straight to the done state; a tick passes through the
// add and update states, then, unless the window sum is zero, through the bit-serial
// divider, which walks through all NUM_W numerator bits, and then to the done state.
// One item is in flight; the next transfer is taken only after the result loads into
// the output register, and an output stall holds the done state.
// Reset clears control state, counters, sum and last stamp; the ring is not cleared.
// ----------------------------------------------------------------------------
// frame_rate_window_average
// Average frame rate over a sliding window of frame intervals kept in a ring
// memory with an exact running sum.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module frame_rate_window_average
	import fwa_pkg::*;
#(
	parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEFAULT
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	localparam int SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
	localparam int SUM_W = STAMP_W + $clog2(WINDOW_DEPTH);
	localparam int MUL_W = $clog2(MS_PER_SECOND * WINDOW_DEPTH + 1);
	localparam int NUM_W = MUL_W + FRACTION_BITS;
	localparam int QUOT_W = (NUM_W > FPS_W) ? NUM_W : FPS_W + 1;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_ADD = 3'd1;
	localparam logic [2:0] S_UPD = 3'd2;
	localparam logic [2:0] S_DIV = 3'd3;
	localparam logic [2:0] S_DONE = 3'd4;

	logic [2:0]         state_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [CNT_W-1:0]   count_q;
	logic [SUM_W-1:0]   sum_q;
	logic [STAMP_W-1:0] last_q;
	logic [STAMP_W-1:0] delta_q;
	logic [SUM_W:0]     sum_plus_q;
	logic [STAMP_W-1:0] rd_data_q;
	logic               out_valid_q;
	result_t            out_q;
	result_t            res_q;

	logic [STAMP_W-1:0] interval_ring [WINDOW_DEPTH];

	logic               accept;
	logic               full;
	logic [CNT_W-1:0]   count_next;
	logic [SUM_W-1:0]   sum_new;
	logic [MUL_W-1:0]   prod;
	logic [NUM_W-1:0]   numer;
	logic               div_start;
	logic               div_done;
	logic [NUM_W-1:0]   div_quot;
	logic [QUOT_W-1:0]  quot_wide;
	logic               out_load;

	assign accept = item_valid && !item_stall;
	assign item_stall = (state_q != S_IDLE);
	assign full = (count_q == CNT_W'(WINDOW_DEPTH));
	assign out_load = (state_q == S_DONE) && (!out_valid_q || !result_stall);

	always_comb begin
		count_next = full ? count_q : count_q + 1'b1;
		sum_new = SUM_W'(sum_plus_q - (full ? (SUM_W + 1)'(rd_data_q) : '0));
		prod = MUL_W'(count_next) * MUL_W'(MS_PER_SECOND);
		numer = {prod, {FRACTION_BITS{1'b0}}};
		div_start = (state_q == S_UPD) && (sum_new != '0);
		quot_wide = QUOT_W'(div_quot);
	end

	always_ff @(posedge clk) begin
		rd_data_q <= interval_ring[slot_q];
		if (state_q == S_UPD) begin
			interval_ring[slot_q] <= delta_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			slot_q <= '0;
			count_q <= '0;
			sum_q <= '0;
			last_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						last_q <= item.now_ms;
						if (item.op == OP_START) begin
							slot_q <= '0;
							count_q <= '0;
							sum_q <= '0;
							state_q <= S_DONE;
						end else begin
							state_q <= S_ADD;
						end
					end
				end
				S_ADD: begin
					state_q <= S_UPD;
				end
				S_UPD: begin
					sum_q <= sum_new;
					count_q <= count_next;
					if (slot_q == SLOT_W'(WINDOW_DEPTH - 1)) begin
						slot_q <= '0;
					end else begin
						slot_q <= slot_q + 1'b1;
					end
					state_q <= (sum_new == '0) ? S_DONE : S_DIV;
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			delta_q <= item.now_ms - last_q;
			res_q.fps_q8 <= '0;
			res_q.saturated <= 1'b0;
		end
		if (state_q == S_ADD) begin
			sum_plus_q <= (SUM_W + 1)'(sum_q) + (SUM_W + 1)'(delta_q);
		end
		if (state_q == S_UPD && sum_new == '0) begin
			res_q.fps_q8 <= FPS_MAX;
			res_q.saturated <= 1'b1;
		end
		if (state_q == S_DIV && div_done) begin
			if (quot_wide > QUOT_W'(FPS_MAX)) begin
				res_q.fps_q8 <= FPS_MAX;
				res_q.saturated <= 1'b1;
			end else begin
				res_q.fps_q8 <= quot_wide[FPS_W-1:0];
				res_q.saturated <= 1'b0;
			end
		end
		if (out_load) begin
			out_q <= res_q;
		end
	end

	fwa_div #(
		.NUM_W(NUM_W),
		.DEN_W(SUM_W)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.numer (numer),
		.denom (sum_new),
		.done  (div_done),
		.quot  (div_quot)
	);

	assign result_valid = out_valid_q;
	assign result = out_q;

	`ASSERT_NEVER(a_count_range, clk, arst_n, count_q > CNT_W'(WINDOW_DEPTH))
	`ASSERT_CLK(a_empty_sum, clk, arst_n, (count_q == '0) |-> (sum_q == '0))
	`ASSERT_CLK(a_div_state, clk, arst_n, div_done |-> (state_q == S_DIV))
	`ASSERT_CLK(a_out_source, clk, arst_n, $rose(result_valid) |-> $past(state_q == S_DONE))

endmodule

// ===== sv/fwa_div.sv =====
// ----------------------------------------------------------------------------
// fwa_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fwa_div
	import fwa_pkg::*;
#(
	parameter int NUM_W = 24,
	parameter int DEN_W = 38
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] numer,
	input  logic [DEN_W-1:0] denom,
	output logic             done,
	output logic [NUM_W-1:0] quot
);

	localparam int STEP_W = $clog2(NUM_W + 1);

	logic [STEP_W-1:0] steps_q;
	logic              busy_q;
	logic              done_q;
	logic [NUM_W-1:0]  num_q;
	logic [DEN_W-1:0]  rem_q;
	logic [DEN_W-1:0]  den_q;
	logic [DEN_W:0]    trial;
	logic [DEN_W:0]    diff;
	logic              qbit;

	always_comb begin
		trial = {rem_q, num_q[NUM_W-1]};
		diff = trial - {1'b0, den_q};
		qbit = (trial >= {1'b0, den_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			steps_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				steps_q <= STEP_W'(NUM_W);
			end else if (busy_q) begin
				steps_q <= steps_q - 1'b1;
				if (steps_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= numer;
			den_q <= denom;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-2:0], qbit};
			rem_q <= qbit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
		end
	end

	assign done = done_q;
	assign quot = num_q;

endmodule

// ===== tb/sv/tb_frame_rate_window_average.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_frame_rate_window_average
// Self-checking bench for the sliding-window frame rate averager. A local
// model of the interval ring and its running sum predicts every result. The
// bench drives directed corner cases and then long random frame sequences,
// with random gaps on the input side and random stalls on the output side.
// ----------------------------------------------------------------------------
module tb_frame_rate_window_average;
	import fwa_pkg::*;

	localparam int DEPTH = WINDOW_DEPTH_DEFAULT;
	localparam int ITEM_TARGET = 1150;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_CYCLES = 120;

	logic clk;
	logic arst_n;
	logic item_valid;
	logic item_stall;
	item_t item;
	logic result_valid;
	logic result_stall;
	result_t result;

	logic [STAMP_W-1:0] win_ring [DEPTH];
	int unsigned win_slot;
	int unsigned win_count;
	logic [63:0] win_sum;
	logic [STAMP_W-1:0] prev_stamp;

	result_t fps_expected [$];
	int unsigned items_sent;
	int unsigned fail_count;
	int unsigned cycle_count;
	bit no_idle;

	frame_rate_window_average #(
		.WINDOW_DEPTH(DEPTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic result_t predict_fps(item_t it);
		result_t r;
		logic [STAMP_W-1:0] gap;
		logic [63:0] numer;
		logic [63:0] quot;
		r = '0;
		if (it.op == OP_START) begin
			win_slot = 0;
			win_count = 0;
			win_sum = '0;
			prev_stamp = it.now_ms;
		end else begin
			gap = it.now_ms - prev_stamp;
			prev_stamp = it.now_ms;
			if (win_count >= DEPTH) begin
				win_sum = win_sum - win_ring[win_slot];
			end else begin
				win_count++;
			end
			win_ring[win_slot] = gap;
			win_sum = win_sum + gap;
			win_slot = (win_slot + 1) % DEPTH;
			if (win_sum == 0) begin
				r.fps_q8 = FPS_MAX;
				r.saturated = 1'b1;
			end else begin
				numer = (64'(MS_PER_SECOND) * 64'(win_count)) << FRACTION_BITS;
				quot = numer / win_sum;
				if (quot > 64'(FPS_MAX)) begin
					r.fps_q8 = FPS_MAX;
					r.saturated = 1'b1;
				end else begin
					r.fps_q8 = quot[FPS_W-1:0];
					r.saturated = 1'b0;
				end
			end
		end
		return r;
	endfunction

	// Called at a falling edge; returns at the falling edge after the transfer.
	task automatic send_item(input logic op, input logic [STAMP_W-1:0] stamp);
		item_t it;
		it.op = op;
		it.now_ms = stamp;
		while (!no_idle && $urandom_range(99) < 9) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		fps_expected.push_back(predict_fps(it));
		items_sent++;
		@(negedge clk);
	endtask

	task automatic test_tick_before_start();
		send_item(OP_TICK, 32'h0000_0000);
		send_item(OP_TICK, 32'h0000_0010);
		send_item(OP_TICK, 32'h0000_0011);
	endtask

	task automatic test_start_and_extremes();
		send_item(OP_START, 32'hFFFF_FFFF);
		send_item(OP_TICK, 32'h0000_000F);
		send_item(OP_START, 32'h0000_0000);
		send_item(OP_TICK, 32'hFFFF_FFFF);
		send_item(OP_TICK, 32'hFFFF_FFFF);
		send_item(OP_START, 32'h1234_5678);
		send_item(OP_TICK, 32'h1234_5678);
		send_item(OP_TICK, 32'h1234_5678);
		send_item(OP_TICK, 32'h1234_5679);
		send_item(OP_START, 32'hAAAA_AAAA);
		send_item(OP_TICK, 32'h5555_5555);
		send_item(OP_START, 32'h8000_0000);
		send_item(OP_TICK, 32'h8000_0001);
		send_item(OP_TICK, 32'h8000_0011);
		send_item(OP_START, 32'h7FFF_FFFE);
		send_item(OP_TICK, 32'h8000_0000);
	endtask

	// A full window and beyond, with neither side idling.
	task automatic test_window_wrap();
		logic [STAMP_W-1:0] stamp;
		no_idle = 1'b1;
		stamp = 32'hFFFF_FF00;
		send_item(OP_START, stamp);
		repeat (3 * DEPTH) begin
			stamp = stamp + $urandom_range(0, 3);
			send_item(OP_TICK, stamp);
		end
		no_idle = 1'b0;
	endtask

	task automatic test_random_frames();
		logic [STAMP_W-1:0] stamp;
		int unsigned ticks;
		int unsigned pick;
		while (items_sent < ITEM_TARGET) begin
			if ($urandom_range(99) < 85) begin
				stamp = $urandom;
				send_item(OP_START, stamp);
				ticks = ($urandom_range(3) == 0) ? $urandom_range(DEPTH, 2 * DEPTH + 20)
					: $urandom_range(1, 40);
				repeat (ticks) begin
					pick = $urandom_range(99);
					if (pick < 75) begin
						stamp = stamp + $urandom_range(5, 60);
					end else if (pick < 88) begin
						stamp = stamp + $urandom_range(0, 3);
					end else if (pick < 94) begin
						stamp = stamp + $urandom;
					end else begin
						stamp = $urandom;
					end
					send_item(OP_TICK, stamp);
				end
			end else begin
				repeat ($urandom_range(1, 6)) begin
					send_item(1'($urandom_range(1)), $urandom);
				end
			end
		end
	endtask

	always @(negedge clk) begin
		result_stall <= (!no_idle && $urandom_range(99) < 9);
	end

	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (fps_expected.size() == 0) begin
				if (fail_count < 10) begin
					$display("unexpected result: fps_q8=%h saturated=%b",
						result.fps_q8, result.saturated);
				end
				fail_count++;
			end else begin
				want = fps_expected.pop_front();
				if (result.fps_q8 !== want.fps_q8 || result.saturated !== want.saturated) begin
					if (fail_count < 10) begin
						$display("mismatch: expected fps_q8=%h saturated=%b, got fps_q8=%h saturated=%b",
							want.fps_q8, want.saturated, result.fps_q8, result.saturated);
					end
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL frame_rate_window_average");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		result_stall = 1'b0;
		no_idle = 1'b0;
		items_sent = 0;
		fail_count = 0;
		cycle_count = 0;
		win_slot = 0;
		win_count = 0;
		win_sum = '0;
		prev_stamp = '0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_tick_before_start();
		test_start_and_extremes();
		test_window_wrap();
		test_random_frames();

		item_valid <= 1'b0;
		while (fps_expected.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && fps_expected.size() == 0) begin
			$display("PASS frame_rate_window_average");
		end else begin
			$display("FAIL frame_rate_window_average");
		end
		$finish;
	end

endmodule
